@@ sv/obstacle_corridor_decision_top_defines.svh @@
// Assertion macros for the obstacle corridor decision block.
`ifndef OBSTACLE_CORRIDOR_DECISION_TOP_DEFINES_SVH
`define OBSTACLE_CORRIDOR_DECISION_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OCC_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define OCC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define OCC_ASSERT_NOW(lbl, pre, post, msg)
`define OCC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ sv/occ_pkg.sv @@
// Shared types, constants and tables of the obstacle corridor decision block.
`default_nettype none
package occ_pkg;
    localparam int OCC_QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFETY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EMERGENCY = 2'd1;
    localparam logic [15:0] SAFETY_RESET = 16'd1280;
    localparam logic [15:0] EMERGENCY_RESET = 16'd512;
    localparam logic [17:0] MIN_LOOK = 18'd2560;
    localparam logic [9:0] HALF_CORRIDOR = 10'd512;
    localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
    localparam logic [30:0] ONE_Q30 = 31'h40000000;
    localparam logic [1:0] DEC_FOLLOW = 2'd0;
    localparam logic [1:0] DEC_REPLAN = 2'd1;
    localparam logic [1:0] DEC_STOP = 2'd2;
    localparam logic [1:0] DEC_ESTOP = 2'd3;

    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [15:0] heading;
        logic [15:0] length;
        logic present;
        logic [17:0] look;
        logic path;
        logic last;
    } occ_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } occ_qstat_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } occ_bstat_t;

    function automatic logic [5:0] div_const(input logic [2:0] k);
        logic [5:0] d;
        case (k)
            3'd0: d = 6'd42;
            3'd1: d = 6'd20;
            3'd2: d = 6'd6;
            3'd3: d = 6'd56;
            3'd4: d = 6'd30;
            default: d = 6'd12;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] div_recip(input logic [2:0] k);
        logic [31:0] m;
        case (k)
            3'd0: m = 32'd102261126;
            3'd1: m = 32'd214748364;
            3'd2: m = 32'd715827882;
            3'd3: m = 32'd76695844;
            3'd4: m = 32'd143165576;
            default: m = 32'd357913941;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

@@ sv/occ_if.sv @@
// Channel interfaces: object items, decisions and register writes.
`default_nettype none
interface occ_in_if;
    logic valid;
    logic ready;
    logic signed [23:0] object_x;
    logic signed [23:0] object_y;
    logic [15:0] object_length;
    logic object_present;
    logic signed [23:0] vehicle_x;
    logic signed [23:0] vehicle_y;
    logic signed [15:0] vehicle_heading;
    logic [15:0] vehicle_speed;
    logic path_available;
    logic frame_last;
    modport source (output valid, object_x, object_y, object_length, object_present,
        vehicle_x, vehicle_y, vehicle_heading, vehicle_speed, path_available,
        frame_last, input ready);
    modport sink (input valid, object_x, object_y, object_length, object_present,
        vehicle_x, vehicle_y, vehicle_heading, vehicle_speed, path_available,
        frame_last, output ready);
endinterface

interface occ_out_if;
    logic valid;
    logic ready;
    logic [1:0] decision;
    logic obstacle_ahead;
    logic signed [23:0] nearest_distance;
    modport source (output valid, decision, obstacle_ahead, nearest_distance, input ready);
    modport sink (input valid, decision, obstacle_ahead, nearest_distance, output ready);
endinterface

interface occ_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/occ_front.sv @@
// Front end: accepts object requests and forms relative position and look-ahead.
`default_nettype none
module occ_front
    import occ_pkg::*;
(
    occ_in_if.sink items,
    input  occ_qstat_t qstat,
    output logic push,
    output occ_item_t entry
);
    logic [17:0] speed3;

    assign speed3 = {2'b00, items.vehicle_speed} + {1'b0, items.vehicle_speed, 1'b0};
    assign items.ready = !qstat.full;
    assign push = items.valid && !qstat.full;

    always_comb
    begin
        entry.dx = {items.object_x[23], items.object_x}
            - {items.vehicle_x[23], items.vehicle_x};
        entry.dy = {items.object_y[23], items.object_y}
            - {items.vehicle_y[23], items.vehicle_y};
        entry.heading = items.vehicle_heading;
        entry.length = items.object_length;
        entry.present = items.object_present;
        entry.look = (speed3 < MIN_LOOK) ? MIN_LOOK : speed3;
        entry.path = items.path_available;
        entry.last = items.frame_last;
    end
endmodule
`default_nettype wire

@@ sv/occ_queue.sv @@
// Short request queue between the front end and the geometry engine.
`default_nettype none
module occ_queue
    import occ_pkg::*;
#(
    parameter int DEPTH = OCC_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  occ_item_t push_data,
    input  logic pop,
    output occ_item_t head,
    output occ_qstat_t stat
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    occ_item_t entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign head = entries[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full = (count_reg == FULL_COUNT);
endmodule
`default_nettype wire

@@ sv/occ_back.sv @@
// Geometry engine: sine and cosine, rotation, range and the frame decision.
`default_nettype none
module occ_back
    import occ_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  occ_item_t head,
    input  occ_qstat_t qstat,
    input  logic [15:0] safety,
    input  logic [15:0] emergency,
    output occ_bstat_t bstat,
    occ_out_if.source results
);
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_X = 5'd1;
    localparam logic [4:0] ST_X2M = 5'd2;
    localparam logic [4:0] ST_X2 = 5'd3;
    localparam logic [4:0] ST_DIVM = 5'd4;
    localparam logic [4:0] ST_DIVW = 5'd5;
    localparam logic [4:0] ST_PM = 5'd6;
    localparam logic [4:0] ST_PV = 5'd7;
    localparam logic [4:0] ST_SM = 5'd8;
    localparam logic [4:0] ST_S = 5'd9;
    localparam logic [4:0] ST_CM = 5'd10;
    localparam logic [4:0] ST_C = 5'd11;
    localparam logic [4:0] ST_R0 = 5'd12;
    localparam logic [4:0] ST_R1 = 5'd13;
    localparam logic [4:0] ST_R2 = 5'd14;
    localparam logic [4:0] ST_R3 = 5'd15;
    localparam logic [4:0] ST_R4 = 5'd16;
    localparam logic [4:0] ST_TEST = 5'd17;
    localparam logic [4:0] ST_D0 = 5'd18;
    localparam logic [4:0] ST_D1 = 5'd19;
    localparam logic [4:0] ST_D2 = 5'd20;
    localparam logic [4:0] ST_SQ = 5'd21;
    localparam logic [4:0] ST_FIN = 5'd22;
    localparam logic [2:0] K_SIN_LAST = 3'd2;
    localparam logic [2:0] K_COS_FIRST = 3'd3;
    localparam logic [2:0] K_COS_LAST = 3'd5;
    localparam logic [4:0] SQ_STEPS = 5'd19;
    localparam logic [39:0] SQ_FIRST_BIT = 40'd1 << 38;

    logic [4:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [4:0] cnt_reg, cnt_next;
    logic frame_start_reg, frame_start_next;
    logic found_reg, found_next;
    logic signed [24:0] min_reg, min_next;
    logic out_valid_reg, out_valid_next;
    logic hit_reg, hit_next;

    occ_item_t item_reg, item_next;
    logic neg_reg, neg_next;
    logic [1:0] quad_reg, quad_next;
    logic [29:0] x_reg, x_next, x2_reg, x2_next, v_reg, v_next, s_reg, s_next;
    logic [30:0] t_reg, t_next;
    logic signed [31:0] sn_reg, sn_next, cs_reg, cs_next;
    logic signed [65:0] mul_reg;
    logic signed [55:0] acc_reg, acc_next;
    logic signed [25:0] lx_reg, lx_next, ly_reg, ly_next;
    logic [39:0] n_reg, n_next, res_reg, res_next, bit_reg, bit_next;
    logic [1:0] dec_reg, dec_next;
    logic ahead_reg, ahead_next;
    logic [23:0] near_reg, near_next;

    logic signed [32:0] mul_a, mul_b;
    logic [15:0] hq_sum, r_val;
    logic [1:0] hq;
    logic [13:0] m_val;
    logic [29:0] q0, q_val;
    logic [35:0] qd, rem;
    logic [5:0] dconst;
    logic [30:0] c_val;
    logic signed [31:0] ss, cc;
    logic signed [55:0] rsum;
    logic [37:0] d2;
    logic [39:0] trial;
    logic signed [22:0] diff;
    logic signed [24:0] obj_dist, base_min, new_min;
    logic base_found, new_found;
    logic signed [25:0] aly;

    assign hq_sum = head.heading + 16'd8192;
    assign hq = hq_sum[15:14];
    assign r_val = head.heading - {hq, 14'd0};
    assign m_val = r_val[15] ? 14'(-r_val) : r_val[13:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = {19'd0, m_val};
                mul_b = {1'b0, PI_Q30};
            end
            ST_X2M:
            begin
                mul_a = {3'd0, x_reg};
                mul_b = {3'd0, x_reg};
            end
            ST_DIVM:
            begin
                mul_a = {3'd0, v_reg};
                mul_b = {1'b0, div_recip(k_reg)};
            end
            ST_PM, ST_CM:
            begin
                mul_a = {3'd0, x2_reg};
                mul_b = {2'd0, t_reg};
            end
            ST_SM:
            begin
                mul_a = {3'd0, x_reg};
                mul_b = {2'd0, t_reg};
            end
            ST_R0:
            begin
                mul_a = {{8{item_reg.dx[24]}}, item_reg.dx};
                mul_b = {cs_reg[31], cs_reg};
            end
            ST_R1:
            begin
                mul_a = {{8{item_reg.dy[24]}}, item_reg.dy};
                mul_b = {sn_reg[31], sn_reg};
            end
            ST_R2:
            begin
                mul_a = {{8{item_reg.dy[24]}}, item_reg.dy};
                mul_b = {cs_reg[31], cs_reg};
            end
            ST_R3:
            begin
                mul_a = {{8{item_reg.dx[24]}}, item_reg.dx};
                mul_b = {sn_reg[31], sn_reg};
            end
            ST_D0:
            begin
                mul_a = {{7{lx_reg[25]}}, lx_reg};
                mul_b = {{7{lx_reg[25]}}, lx_reg};
            end
            ST_D1:
            begin
                mul_a = {{7{ly_reg[25]}}, ly_reg};
                mul_b = {{7{ly_reg[25]}}, ly_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        dconst = div_const(k_reg);
        q0 = mul_reg[61:32];
        qd = q0 * dconst;
        rem = {6'd0, v_reg} - qd;
        q_val = q0 + {29'd0, (rem >= {30'd0, dconst})};
        c_val = ONE_Q30 - {2'd0, mul_reg[59:31]};
        ss = neg_reg ? -$signed({2'b00, s_reg}) : $signed({2'b00, s_reg});
        cc = $signed({1'b0, c_val});
        rsum = (state_reg == ST_R2) ? (acc_reg + mul_reg[55:0])
                                    : (acc_reg - mul_reg[55:0]);
        rsum = rsum + 56'sd536870912;
        d2 = acc_reg[37:0] + mul_reg[37:0];
        trial = res_reg + bit_reg;
        aly = ly_reg[25] ? -ly_reg : ly_reg;
        diff = $signed({2'b00, res_reg[20:0]}) - $signed({7'd0, item_reg.length});
        obj_dist = 25'(diff >>> 1);
        base_found = frame_start_reg ? 1'b0 : found_reg;
        base_min = frame_start_reg ? $signed({7'd0, item_reg.look}) : min_reg;
        new_found = base_found || hit_reg;
        new_min = (hit_reg && (obj_dist < base_min)) ? obj_dist : base_min;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        cnt_next = cnt_reg;
        frame_start_next = frame_start_reg;
        found_next = found_reg;
        min_next = min_reg;
        out_valid_next = out_valid_reg && !results.ready;
        hit_next = hit_reg;
        item_next = item_reg;
        neg_next = neg_reg;
        quad_next = quad_reg;
        x_next = x_reg;
        x2_next = x2_reg;
        v_next = v_reg;
        s_next = s_reg;
        t_next = t_reg;
        sn_next = sn_reg;
        cs_next = cs_reg;
        acc_next = acc_reg;
        lx_next = lx_reg;
        ly_next = ly_reg;
        n_next = n_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        dec_next = dec_reg;
        ahead_next = ahead_reg;
        near_next = near_reg;
        bstat.pop = 1'b0;
        bstat.busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    bstat.pop = 1'b1;
                    item_next = head;
                    neg_next = r_val[15];
                    quad_next = hq;
                    hit_next = 1'b0;
                    state_next = head.present ? ST_X : ST_FIN;
                end
            end
            ST_X:
            begin
                x_next = mul_reg[44:15];
                state_next = ST_X2M;
            end
            ST_X2M:
            begin
                state_next = ST_X2;
            end
            ST_X2:
            begin
                x2_next = mul_reg[59:30];
                v_next = mul_reg[59:30];
                k_next = '0;
                state_next = ST_DIVM;
            end
            ST_DIVM:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                t_next = ONE_Q30 - {1'b0, q_val};
                if (k_reg == K_SIN_LAST)
                begin
                    state_next = ST_SM;
                end
                else if (k_reg == K_COS_LAST)
                begin
                    state_next = ST_CM;
                end
                else
                begin
                    state_next = ST_PM;
                end
            end
            ST_PM:
            begin
                state_next = ST_PV;
            end
            ST_PV:
            begin
                v_next = mul_reg[59:30];
                k_next = k_reg + 1'b1;
                state_next = ST_DIVM;
            end
            ST_SM:
            begin
                state_next = ST_S;
            end
            ST_S:
            begin
                s_next = mul_reg[59:30];
                v_next = x2_reg;
                k_next = K_COS_FIRST;
                state_next = ST_DIVM;
            end
            ST_CM:
            begin
                state_next = ST_C;
            end
            ST_C:
            begin
                case (quad_reg)
                    2'd0:
                    begin
                        sn_next = ss;
                        cs_next = cc;
                    end
                    2'd1:
                    begin
                        sn_next = cc;
                        cs_next = -ss;
                    end
                    2'd2:
                    begin
                        sn_next = -ss;
                        cs_next = -cc;
                    end
                    default:
                    begin
                        sn_next = -cc;
                        cs_next = ss;
                    end
                endcase
                state_next = ST_R0;
            end
            ST_R0:
            begin
                state_next = ST_R1;
            end
            ST_R1:
            begin
                acc_next = mul_reg[55:0];
                state_next = ST_R2;
            end
            ST_R2:
            begin
                lx_next = rsum[55:30];
                state_next = ST_R3;
            end
            ST_R3:
            begin
                acc_next = mul_reg[55:0];
                state_next = ST_R4;
            end
            ST_R4:
            begin
                ly_next = rsum[55:30];
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (!lx_reg[25] && (lx_reg != '0) && (lx_reg < $signed({8'd0, item_reg.look}))
                    && (aly < $signed({16'd0, HALF_CORRIDOR})))
                begin
                    hit_next = 1'b1;
                    state_next = ST_D0;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_D0:
            begin
                state_next = ST_D1;
            end
            ST_D1:
            begin
                acc_next = mul_reg[55:0];
                state_next = ST_D2;
            end
            ST_D2:
            begin
                n_next = {d2, 2'b00};
                res_next = '0;
                bit_next = SQ_FIRST_BIT;
                cnt_next = SQ_STEPS;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (n_reg >= trial)
                begin
                    n_next = n_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!item_reg.last)
                begin
                    frame_start_next = 1'b0;
                    found_next = new_found;
                    min_next = new_min;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || results.ready)
                begin
                    frame_start_next = 1'b1;
                    found_next = new_found;
                    min_next = new_min;
                    out_valid_next = 1'b1;
                    ahead_next = new_found;
                    near_next = new_min[23:0];
                    if (new_found && (new_min < $signed({9'd0, emergency})))
                    begin
                        dec_next = DEC_ESTOP;
                    end
                    else if (new_found && (new_min < $signed({9'd0, safety})))
                    begin
                        dec_next = DEC_STOP;
                    end
                    else if (item_reg.path)
                    begin
                        dec_next = new_found ? DEC_REPLAN : DEC_FOLLOW;
                    end
                    else
                    begin
                        dec_next = DEC_REPLAN;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg <= '0;
            cnt_reg <= '0;
            frame_start_reg <= 1'b1;
            found_reg <= 1'b0;
            min_reg <= '0;
            out_valid_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
            frame_start_reg <= frame_start_next;
            found_reg <= found_next;
            min_reg <= min_next;
            out_valid_reg <= out_valid_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        neg_reg <= neg_next;
        quad_reg <= quad_next;
        x_reg <= x_next;
        x2_reg <= x2_next;
        v_reg <= v_next;
        s_reg <= s_next;
        t_reg <= t_next;
        sn_reg <= sn_next;
        cs_reg <= cs_next;
        mul_reg <= mul_a * mul_b;
        acc_reg <= acc_next;
        lx_reg <= lx_next;
        ly_reg <= ly_next;
        n_reg <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        dec_reg <= dec_next;
        ahead_reg <= ahead_next;
        near_reg <= near_next;
    end

    assign results.valid = out_valid_reg;
    assign results.decision = dec_reg;
    assign results.obstacle_ahead = ahead_reg;
    assign results.nearest_distance = near_reg;
endmodule
`default_nettype wire

@@ sv/obstacle_corridor_decision_top.sv @@
// Top level of the obstacle corridor decision block.
// The items channel takes one detected object per request, with the vehicle pose,
// speed and path flag repeated; frame_last marks the final request of a frame.
// The results channel carries one decision per frame, issued for the last request.
// The cfg channel writes the safety (index 0) and emergency (index 1) distances;
// it is always ready and other indices are ignored.
// A request that carries no object skips the engine's arithmetic; an object outside
// the corridor runs the shared multiplier sequence for sine, cosine and rotation,
// and an object inside it also the distance and the 20-step square root.
// The registered decision appears in the cycle after the last request finishes.
// A queue between the front end and the engine lets requests be taken while the
// engine works or while a decision waits in the output register.
// Reset empties the queue, restores the register defaults and opens a new frame.
// When the receiver stalls, the decision is held, the engine stops at the next
// frame end and the queue fills before items.ready falls.
`default_nettype none
module obstacle_corridor_decision_top
    import occ_pkg::*;
#(
    parameter int QUEUE_DEPTH = OCC_QUEUE_DEPTH
)
(
    input wire logic clk,
    input wire logic rst_n,
    occ_in_if.sink items,
    occ_out_if.source results,
    occ_cfg_if.sink cfg
);
    `include "obstacle_corridor_decision_top_defines.svh"

    logic [15:0] safety_reg, safety_next, emergency_reg, emergency_next;
    logic push;
    occ_item_t entry, head;
    occ_qstat_t qstat;
    occ_bstat_t bstat;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        safety_next = safety_reg;
        emergency_next = emergency_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SAFETY: safety_next = cfg.data;
                REG_EMERGENCY: emergency_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safety_reg <= SAFETY_RESET;
            emergency_reg <= EMERGENCY_RESET;
        end
        else
        begin
            safety_reg <= safety_next;
            emergency_reg <= emergency_next;
        end
    end

    occ_front u_front (
        .items(items),
        .qstat(qstat),
        .push(push),
        .entry(entry)
    );

    occ_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(entry),
        .pop(bstat.pop),
        .head(head),
        .stat(qstat)
    );

    occ_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .qstat(qstat),
        .safety(safety_reg),
        .emergency(emergency_reg),
        .bstat(bstat),
        .results(results)
    );

    `OCC_ASSERT_NEXT(a_push_fills, push, !qstat.empty, "queue empty after a push")
    `OCC_ASSERT_NOW(a_pop_nonempty, bstat.pop, !qstat.empty, "pop from an empty queue")
    `OCC_ASSERT_NOW(a_result_from_engine, $rose(results.valid), $past(bstat.busy),
        "decision raised without engine activity")
endmodule
`default_nettype wire

@@ tb/sv/occ_tb_if.sv @@
// Request and verdict types shared by the testbench.
`default_nettype none
package occ_tb_types;
    timeunit 1ns;
    timeprecision 1ps;
    typedef struct {
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic [15:0] len;
        logic present;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [15:0] heading;
        logic [15:0] speed;
        logic path;
        logic last;
    } obj_req_t;

    typedef struct {
        logic [1:0] decision;
        logic ahead;
        logic signed [23:0] nearest;
    } verdict_t;
endpackage
`default_nettype wire

@@ tb/sv/obstacle_corridor_decision_top_tb.sv @@
// Self-checking testbench of the obstacle corridor decision block with its own corridor predictor.
`default_nettype none
module obstacle_corridor_decision_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import occ_pkg::*;
    import occ_tb_types::*;

    logic clk;
    logic rst_n;
    int errors;
    longint cycles;
    bit rx_stall_mode;

    occ_in_if items ();
    occ_out_if results ();
    occ_cfg_if cfg ();

    obstacle_corridor_decision_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items.sink),
        .results(results.source),
        .cfg(cfg.sink)
    );

    logic [15:0] safety_thr;
    logic [15:0] emergency_thr;
    bit opening;
    bit seen_obstacle;
    longint frame_min;
    verdict_t pending_verdicts[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void heading_sin_cos(input logic [15:0] h, output longint sn,
        output longint cs);
        longint unsigned one;
        longint unsigned u;
        longint unsigned q;
        longint r;
        bit neg;
        longint unsigned m;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned c;
        longint ss;
        longint cc;
        one = 64'd1 << 30;
        u = h;
        q = ((u + 8192) >> 14) & 3;
        r = longint'((u - q * 16384) & 64'hFFFF);
        if (r >= 32768)
            r -= 65536;
        neg = r < 0;
        m = neg ? -r : r;
        x = (m * 64'd3373259426) >> 15;
        x2 = (x * x) >> 30;
        t = one - x2 / 42;
        t = one - ((x2 * t) >> 30) / 20;
        t = one - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        t = one - x2 / 56;
        t = one - ((x2 * t) >> 30) / 30;
        t = one - ((x2 * t) >> 30) / 12;
        c = one - ((x2 * t) >> 30) / 2;
        ss = neg ? -longint'(s) : longint'(s);
        cc = longint'(c);
        case (q)
            0: begin sn = ss; cs = cc; end
            1: begin sn = cc; cs = -ss; end
            2: begin sn = -ss; cs = -cc; end
            default: begin sn = -cc; cs = ss; end
        endcase
    endfunction

    function automatic longint q30_to_grid(input longint v);
        return (v + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void predict_corridor(input obj_req_t rq);
        longint look;
        longint dx;
        longint dy;
        longint sn;
        longint cs;
        longint lx;
        longint ly;
        longint obj_dist;
        verdict_t v;
        look = longint'(rq.speed) * 3;
        if (look < 2560)
            look = 2560;
        if (opening)
        begin
            seen_obstacle = 0;
            frame_min = look;
            opening = 0;
        end
        if (rq.present)
        begin
            dx = longint'(rq.ox) - longint'(rq.vx);
            dy = longint'(rq.oy) - longint'(rq.vy);
            heading_sin_cos(rq.heading, sn, cs);
            lx = q30_to_grid(dx * cs + dy * sn);
            ly = q30_to_grid(dy * cs - dx * sn);
            if (lx > 0 && lx < look && (ly < 0 ? -ly : ly) < 512)
            begin
                obj_dist = (longint'(int_sqrt(4 * longint'(lx * lx + ly * ly)))
                    - longint'(rq.len)) >>> 1;
                seen_obstacle = 1;
                if (obj_dist < frame_min)
                    frame_min = obj_dist;
            end
        end
        if (rq.last)
        begin
            if (seen_obstacle && frame_min < longint'(emergency_thr))
                v.decision = DEC_ESTOP;
            else if (seen_obstacle && frame_min < longint'(safety_thr))
                v.decision = DEC_STOP;
            else if (rq.path)
                v.decision = seen_obstacle ? DEC_REPLAN : DEC_FOLLOW;
            else
                v.decision = DEC_REPLAN;
            v.ahead = seen_obstacle;
            v.nearest = frame_min[23:0];
            pending_verdicts.push_back(v);
            opening = 1;
        end
    endfunction

    initial
    begin
        verdict_t e;
        int rx_wait;
        rx_wait = 0;
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (results.valid && results.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t unexpected decision %0d", $time, results.decision);
                    errors++;
                end
                else
                begin
                    e = pending_verdicts.pop_front();
                    if (e.decision !== results.decision)
                    begin
                        $display("%0t decision exp %0d got %0d", $time, e.decision,
                            results.decision);
                        errors++;
                    end
                    if (e.ahead !== results.obstacle_ahead)
                    begin
                        $display("%0t obstacle_ahead exp %0d got %0d", $time, e.ahead,
                            results.obstacle_ahead);
                        errors++;
                    end
                    if (e.nearest !== results.nearest_distance)
                    begin
                        $display("%0t nearest_distance exp %0d got %0d", $time, e.nearest,
                            results.nearest_distance);
                        errors++;
                    end
                end
                rx_wait = rx_stall_mode ? int'($urandom_range(0, 10)) : 0;
            end
            if (rx_wait > 0)
            begin
                results.ready <= 1'b0;
                rx_wait--;
            end
            else
                results.ready <= 1'b1;
        end
    end

    task automatic send_request(input obj_req_t rq);
        int gap;
        gap = rx_stall_mode ? int'($urandom_range(0, 10)) : 0;
        if (gap > 0)
        begin
            items.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.object_x <= rq.ox;
        items.object_y <= rq.oy;
        items.object_length <= rq.len;
        items.object_present <= rq.present;
        items.vehicle_x <= rq.vx;
        items.vehicle_y <= rq.vy;
        items.vehicle_heading <= rq.heading;
        items.vehicle_speed <= rq.speed;
        items.path_available <= rq.path;
        items.frame_last <= rq.last;
        do
            @(posedge clk);
        while (!items.ready);
        predict_corridor(rq);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_SAFETY)
            safety_thr = val;
        else if (idx == REG_EMERGENCY)
            emergency_thr = val;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        items.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic obj_req_t random_object(input bit last);
        obj_req_t rq;
        int ang;
        int rng;
        int lat;
        rq.vx = 24'($urandom);
        rq.vy = 24'($urandom);
        rq.heading = 16'($urandom);
        rq.speed = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        rq.len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
        rq.present = ($urandom_range(0, 9) != 0);
        rq.path = 1'($urandom);
        rq.last = last;
        if ($urandom_range(0, 4) == 0)
        begin
            rq.ox = 24'($urandom);
            rq.oy = 24'($urandom);
        end
        else
        begin
            // Place the object near the corridor so that many land inside it.
            rng = int'($urandom_range(0, 7000)) - 200;
            lat = int'($urandom_range(0, 1200)) - 600;
            ang = rq.heading;
            rq.ox = rq.vx + 24'(int'($cos(ang * 3.14159265358979 / 32768.0) * rng
                - $sin(ang * 3.14159265358979 / 32768.0) * lat));
            rq.oy = rq.vy + 24'(int'($sin(ang * 3.14159265358979 / 32768.0) * rng
                + $cos(ang * 3.14159265358979 / 32768.0) * lat));
        end
        return rq;
    endfunction

    task automatic test_directed_extremes();
        obj_req_t rq;
        rq = '{24'sd1000, 24'sd0, 16'd0, 1'b1, 24'sd0, 24'sd0, 16'sd0, 16'd0, 1'b1, 1'b1};
        send_request(rq);
        rq.ox = 24'sd300;
        send_request(rq);
        rq.ox = 24'sd2000; rq.len = 16'hFFFF;
        send_request(rq);
        rq.present = 1'b0; rq.path = 1'b1;
        send_request(rq);
        rq.path = 1'b0;
        send_request(rq);
        rq.present = 1'b1; rq.ox = 24'sd100; rq.oy = 24'sd600; rq.path = 1'b1;
        send_request(rq);
        rq = '{24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 1'b1, 24'sh800000, 24'sh800000,
            16'sh8000, 16'hFFFF, 1'b1, 1'b0};
        send_request(rq);
        rq = '{24'sh800000, 24'sh800000, 16'd0, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF,
            16'sh7FFF, 16'd0, 1'b0, 1'b1};
        send_request(rq);
        rq = '{24'sd0, 24'sd1500, 16'd256, 1'b1, 24'sd0, 24'sd0, 16'sd16384, 16'd900, 1'b1,
            1'b0};
        send_request(rq);
        rq.oy = 24'sd700; rq.speed = 16'd10;
        send_request(rq);
        rq = '{24'sd0, -24'sd1000, 16'd0, 1'b1, 24'sd0, 24'sd0, -16'sd16384, 16'd0, 1'b1,
            1'b1};
        send_request(rq);
        rq = '{-24'sd900, 24'sd0, 16'd0, 1'b1, 24'sd0, 24'sd0, 16'sh8000, 16'd0, 1'b1, 1'b1};
        send_request(rq);
        rq.ox = 24'sd900;
        send_request(rq);
        rq = '{24'sd0, 24'sd0, 16'd0, 1'b1, 24'sd0, 24'sd0, 16'sd8192, 16'd0, 1'b1, 1'b1};
        send_request(rq);
        rq = '{24'sd2559, 24'sd0, 16'd0, 1'b1, 24'sd0, 24'sd0, -16'sd8192, 16'd0, 1'b1, 1'b1};
        send_request(rq);
        rq.heading = 16'sd0;
        send_request(rq);
        wait_drained();
    endtask

    task automatic test_registers();
        write_register(REG_SAFETY, 16'hFFFF);
        write_register(REG_EMERGENCY, 16'd0);
        write_register(2'd2, 16'd5);
        write_register(2'd3, 16'd7);
    endtask

    task automatic test_random_frames(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n)
        begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                send_request(random_object(i == len - 1));
            sent += len;
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        rx_stall_mode = 1'b1;
        opening = 1;
        seen_obstacle = 0;
        frame_min = 0;
        safety_thr = SAFETY_RESET;
        emergency_thr = EMERGENCY_RESET;
        rst_n = 1'b0;
        items.valid <= 1'b0;
        items.object_x <= '0;
        items.object_y <= '0;
        items.object_length <= '0;
        items.object_present <= 1'b0;
        items.vehicle_x <= '0;
        items.vehicle_y <= '0;
        items.vehicle_heading <= '0;
        items.vehicle_speed <= '0;
        items.path_available <= 1'b0;
        items.frame_last <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_random_frames(200);
        test_registers();
        test_directed_extremes();
        rx_stall_mode = 1'b0;
        test_random_frames(100);
        rx_stall_mode = 1'b1;
        write_register(REG_SAFETY, 16'd0);
        write_register(REG_EMERGENCY, 16'hFFFF);
        test_random_frames(150);
        write_register(REG_SAFETY, 16'd3000);
        write_register(REG_EMERGENCY, 16'd1000);
        test_random_frames(250);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
